FILE: design/fbx_pkg.sv
// ----------------------------------------------------------------------------
// fbx_pkg
// shared types, constants and the stage table of the four-band crossover
// ----------------------------------------------------------------------------
package fbx_pkg;

  localparam int DEF_CHANNELS    = 64;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_COEF_BITS   = 32;

  localparam int STAGES      = 14;
  localparam int STATE_BITS  = 48;
  localparam int COEF_FRAC   = 30;
  localparam int STATE_SHIFT = 13;
  localparam int CFG_AW      = 6;
  localparam int CFG_DW      = 64;
  localparam int CHAN_BITS   = 6;
  localparam int MUL_A_BITS  = 34;

  // register indexes
  localparam logic [2:0] REG_LOW_POLES  = 3'd0;
  localparam logic [2:0] REG_LOW_GAINS  = 3'd1;
  localparam logic [2:0] REG_MID_POLES  = 3'd2;
  localparam logic [2:0] REG_MID_GAINS  = 3'd3;
  localparam logic [2:0] REG_HIGH_POLES = 3'd4;
  localparam logic [2:0] REG_HIGH_GAINS = 3'd5;
  localparam logic [2:0] REG_SOLO_MASK  = 3'd6;

  typedef enum logic [1:0] {KIND_LP = 2'd0, KIND_HP = 2'd1, KIND_AP = 2'd2} kind_t;
  typedef enum logic [1:0] {XO_LOW = 2'd0, XO_MID = 2'd1, XO_HIGH = 2'd2} xo_t;
  typedef enum logic [1:0] {SRC_X = 2'd0, SRC_PREV = 2'd1, SRC_LO = 2'd2, SRC_HI = 2'd3} src_t;
  typedef enum logic [2:0] {
    DST_PREV  = 3'd0,
    DST_LO    = 3'd1,
    DST_HI    = 3'd2,
    DST_BAND0 = 3'd3,
    DST_BAND1 = 3'd4,
    DST_BAND2 = 3'd5,
    DST_BAND3 = 3'd6
  } dst_t;

  typedef struct packed {
    kind_t kind;
    xo_t   xo;
    src_t  src;
    dst_t  dst;
  } stage_info_t;

  typedef struct packed {
    logic [2:0][63:0] poles;
    logic [2:0][63:0] gains;
    logic [3:0]       solo;
  } cfg_t;

  // routing of the biquad tree, one entry per stage
  function automatic stage_info_t stage_info(input logic [3:0] idx);
    stage_info_t si;
    case (idx)
      4'd0:    si = '{KIND_LP, XO_MID,  SRC_X,    DST_PREV};
      4'd1:    si = '{KIND_LP, XO_MID,  SRC_PREV, DST_LO};
      4'd2:    si = '{KIND_HP, XO_MID,  SRC_X,    DST_PREV};
      4'd3:    si = '{KIND_HP, XO_MID,  SRC_PREV, DST_HI};
      4'd4:    si = '{KIND_AP, XO_HIGH, SRC_LO,   DST_LO};
      4'd5:    si = '{KIND_AP, XO_LOW,  SRC_HI,   DST_HI};
      4'd6:    si = '{KIND_HP, XO_LOW,  SRC_LO,   DST_PREV};
      4'd7:    si = '{KIND_HP, XO_LOW,  SRC_PREV, DST_BAND1};
      4'd8:    si = '{KIND_LP, XO_LOW,  SRC_LO,   DST_PREV};
      4'd9:    si = '{KIND_LP, XO_LOW,  SRC_PREV, DST_BAND0};
      4'd10:   si = '{KIND_LP, XO_HIGH, SRC_HI,   DST_PREV};
      4'd11:   si = '{KIND_LP, XO_HIGH, SRC_PREV, DST_BAND2};
      4'd12:   si = '{KIND_HP, XO_HIGH, SRC_HI,   DST_PREV};
      4'd13:   si = '{KIND_HP, XO_HIGH, SRC_PREV, DST_BAND3};
      default: si = '{KIND_LP, XO_MID,  SRC_X,    DST_PREV};
    endcase
    return si;
  endfunction

  // round half up by 2^13 and saturate to a 48-bit state word
  function automatic logic signed [STATE_BITS-1:0] state_round(input logic signed [63:0] v);
    logic signed [63:0] r;
    logic signed [63:0] smax;
    logic signed [63:0] smin;
    smax = (64'sd1 <<< (STATE_BITS - 1)) - 64'sd1;
    smin = -smax - 64'sd1;
    r = (v + (64'sd1 <<< (STATE_SHIFT - 1))) >>> STATE_SHIFT;
    if (r > smax) begin
      r = smax;
    end else if (r < smin) begin
      r = smin;
    end
    return r[STATE_BITS-1:0];
  endfunction

endpackage

FILE: design/fbx_regs.sv
// ----------------------------------------------------------------------------
// fbx_regs
// apb register file holding the crossover coefficients and the solo mask
// ----------------------------------------------------------------------------
module fbx_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fbx_pkg::CFG_AW-1:0] paddr,
  input  logic [fbx_pkg::CFG_DW-1:0] pwdata,
  output logic [fbx_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output fbx_pkg::cfg_t              cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[fbx_pkg::CFG_AW-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        fbx_pkg::REG_LOW_POLES:  cfg.poles[0] <= pwdata;
        fbx_pkg::REG_LOW_GAINS:  cfg.gains[0] <= pwdata;
        fbx_pkg::REG_MID_POLES:  cfg.poles[1] <= pwdata;
        fbx_pkg::REG_MID_GAINS:  cfg.gains[1] <= pwdata;
        fbx_pkg::REG_HIGH_POLES: cfg.poles[2] <= pwdata;
        fbx_pkg::REG_HIGH_GAINS: cfg.gains[2] <= pwdata;
        fbx_pkg::REG_SOLO_MASK:  cfg.solo     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fbx_pkg::REG_LOW_POLES:  prdata = cfg.poles[0];
      fbx_pkg::REG_LOW_GAINS:  prdata = cfg.gains[0];
      fbx_pkg::REG_MID_POLES:  prdata = cfg.poles[1];
      fbx_pkg::REG_MID_GAINS:  prdata = cfg.gains[1];
      fbx_pkg::REG_HIGH_POLES: prdata = cfg.poles[2];
      fbx_pkg::REG_HIGH_GAINS: prdata = cfg.gains[2];
      fbx_pkg::REG_SOLO_MASK:  prdata = {60'd0, cfg.solo};
      default:                 prdata = '0;
    endcase
  end

endmodule

FILE: design/fbx_mul.sv
// ----------------------------------------------------------------------------
// fbx_mul
// shared signed multiplier, product registered and cast to 64 bits
// ----------------------------------------------------------------------------
module fbx_mul #(
  parameter int SAMPLE_BITS = fbx_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic signed [fbx_pkg::MUL_A_BITS-1:0]  a,
  input  logic signed [SAMPLE_BITS-1:0]          b,
  output logic signed [63:0]                     prod
);

  logic signed [fbx_pkg::MUL_A_BITS+SAMPLE_BITS-1:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    prod <= 64'(full);
  end

endmodule

FILE: design/fbx_state_mem.sv
// ----------------------------------------------------------------------------
// fbx_state_mem
// biquad state memory, one row holds both state words of one biquad
// ----------------------------------------------------------------------------
module fbx_state_mem #(
  parameter int ROWS = fbx_pkg::DEF_CHANNELS * fbx_pkg::STAGES,
  parameter int AW   = $clog2(ROWS)
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [AW-1:0]                      waddr,
  input  logic [2*fbx_pkg::STATE_BITS-1:0]   wdata,
  input  logic [AW-1:0]                      raddr,
  output logic [2*fbx_pkg::STATE_BITS-1:0]   rdata
);

  logic [2*fbx_pkg::STATE_BITS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/four_band_crossover_splitter_core.sv
// ----------------------------------------------------------------------------
// four_band_crossover_splitter_core
// four-band lr4 crossover tree of 14 biquads on one shared multiplier
// ----------------------------------------------------------------------------
// usage
//   samples come in on the sample channel (channel, sample_in) with
//   sample_valid / sample_ready; one sample is worked on at a time and
//   sample_ready is high only while the core is idle
//   each sample runs 14 biquad stages on the one multiplier, each stage
//   stepping through read state and b0*x, b1*x, a1*y, b2*x, a2*y and write
//   back; before them the channel is folded below CHANNELS by repeated
//   subtraction of CHANNELS when channel >= CHANNELS, and after them the
//   output register is loaded; the next sample is taken only once the
//   result is loaded and the core is back in idle
//   results (channel_out, four bands, mix_out) sit in an output register with
//   result_valid / result_ready; a stalled receiver holds the result and the
//   core waits before loading the next one
//   after rst the coefficient registers are zero and a clearing pass writes
//   zero to all CHANNELS*14 state rows, one per cycle
//   with sample_ready low; apb writes are taken at any time
//   the user, unchecked by the core, makes coefficient writes while the core is idle
// ----------------------------------------------------------------------------
module four_band_crossover_splitter_core #(
  parameter int CHANNELS    = fbx_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = fbx_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_BITS   = fbx_pkg::DEF_COEF_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // apb configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbx_pkg::CFG_AW-1:0]    paddr,
  input  logic [fbx_pkg::CFG_DW-1:0]    pwdata,
  output logic [fbx_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  // sample channel
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic [fbx_pkg::CHAN_BITS-1:0] channel,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  // result channel
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [fbx_pkg::CHAN_BITS-1:0] channel_out,
  output logic signed [SAMPLE_BITS-1:0] band_low,
  output logic signed [SAMPLE_BITS-1:0] band_midlow,
  output logic signed [SAMPLE_BITS-1:0] band_midhigh,
  output logic signed [SAMPLE_BITS-1:0] band_high,
  output logic signed [SAMPLE_BITS-1:0] mix_out
);

  localparam int ROWS = CHANNELS * fbx_pkg::STAGES;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SB   = SAMPLE_BITS;
  localparam int AB   = fbx_pkg::MUL_A_BITS;
  localparam int SW   = fbx_pkg::STATE_BITS;
  localparam logic [31:0] COEF_KEEP = ~((32'd1 << (32 - COEF_BITS)) - 32'd1);
  localparam logic signed [63:0] SMAX = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;
  localparam logic signed [SB+1:0] MMAX = (SB+2)'(SMAX);
  localparam logic signed [SB+1:0] MMIN = (SB+2)'(SMIN);
  localparam logic [fbx_pkg::CHAN_BITS:0] CH_LIMIT =
    (CHANNELS > 63) ? 7'd64 : 7'(CHANNELS);

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b00000000001,
    ST_IDLE  = 11'b00000000010,
    ST_FOLD  = 11'b00000000100,
    ST_RD    = 11'b00000001000,
    ST_Y     = 11'b00000010000,
    ST_P1    = 11'b00000100000,
    ST_P2    = 11'b00001000000,
    ST_P3    = 11'b00010000000,
    ST_P4    = 11'b00100000000,
    ST_WR    = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  fbx_pkg::cfg_t        cfg;
  fbx_pkg::stage_info_t si;

  logic [AW-1:0]                   row;
  logic [3:0]                      stage;
  logic [fbx_pkg::CHAN_BITS-1:0]   ch_id;
  logic [fbx_pkg::CHAN_BITS-1:0]   ch_fold;
  logic [fbx_pkg::CHAN_BITS+3:0]   ch_x14;
  logic signed [SB-1:0]            x_in;
  logic signed [SB-1:0]            prev;
  logic signed [SB-1:0]            lo;
  logic signed [SB-1:0]            hi;
  logic signed [SB-1:0]            band [4];
  logic signed [SB-1:0]            y_r;
  logic signed [SB-1:0]            x_sel;
  logic signed [63:0]              acc1;
  logic signed [63:0]              acc2;

  // multiplier and memory hookup
  logic signed [AB-1:0]            mul_a;
  logic signed [SB-1:0]            mul_b;
  logic signed [63:0]              prod;
  logic                            mem_we;
  logic [2*SW-1:0]                 mem_wdata;
  logic [2*SW-1:0]                 mem_rdata;
  logic signed [SW-1:0]            s1;
  logic signed [SW-1:0]            s2;

  // stage coefficients
  logic signed [31:0]              c_a1;
  logic signed [31:0]              c_a2;
  logic signed [31:0]              c_g;
  logic signed [AB-1:0]            c_b0;
  logic signed [AB-1:0]            c_b1;
  logic signed [AB-1:0]            c_b2;

  logic signed [63:0]              y_acc;
  logic signed [63:0]              y_sh;
  logic signed [SB-1:0]            y_sat;
  logic signed [SB+1:0]            mix_sum;
  logic signed [SB-1:0]            mix_sat;

  fbx_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fbx_mul #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  fbx_state_mem #(
    .ROWS (ROWS),
    .AW   (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (row),
    .wdata (mem_wdata),
    .raddr (row),
    .rdata (mem_rdata)
  );

  assign si = fbx_pkg::stage_info(stage);
  assign s1 = mem_rdata[2*SW-1:SW];
  assign s2 = mem_rdata[SW-1:0];

  // coefficient words of the current stage, low bits cleared past COEF_BITS
  always_comb begin
    c_a1 = cfg.poles[si.xo][63:32] & COEF_KEEP;
    c_a2 = cfg.poles[si.xo][31:0] & COEF_KEEP;
    if (si.kind == fbx_pkg::KIND_LP) begin
      c_g = cfg.gains[si.xo][63:32] & COEF_KEEP;
    end else begin
      c_g = cfg.gains[si.xo][31:0] & COEF_KEEP;
    end
    case (si.kind)
      fbx_pkg::KIND_LP: begin
        c_b0 = AB'(c_g);
        c_b1 = AB'(c_g) <<< 1;
        c_b2 = AB'(c_g);
      end
      fbx_pkg::KIND_HP: begin
        c_b0 = AB'(c_g);
        c_b1 = -(AB'(c_g) <<< 1);
        c_b2 = AB'(c_g);
      end
      default: begin
        // allpass: b = (a2, a1, 1.0)
        c_b0 = AB'(c_a2);
        c_b1 = AB'(c_a1);
        c_b2 = AB'(64'sd1 <<< fbx_pkg::COEF_FRAC);
      end
    endcase
  end

  // stage input
  always_comb begin
    case (si.src)
      fbx_pkg::SRC_X:    x_sel = x_in;
      fbx_pkg::SRC_PREV: x_sel = prev;
      fbx_pkg::SRC_LO:   x_sel = lo;
      default:           x_sel = hi;
    endcase
  end

  // multiplier operands per step
  always_comb begin
    mul_a = c_b0;
    mul_b = x_sel;
    case (state)
      ST_Y: begin
        mul_a = c_b1;
        mul_b = x_sel;
      end
      ST_P1: begin
        mul_a = AB'(c_a1);
        mul_b = y_r;
      end
      ST_P2: begin
        mul_a = c_b2;
        mul_b = x_sel;
      end
      ST_P3: begin
        mul_a = AB'(c_a2);
        mul_b = y_r;
      end
      default: begin
        mul_a = c_b0;
        mul_b = x_sel;
      end
    endcase
  end

  // stage output: (b0*x + s1*2^13) rounded by 2^30, saturated
  always_comb begin
    y_acc = prod + (64'(s1) <<< fbx_pkg::STATE_SHIFT);
    y_sh  = (y_acc + (64'sd1 <<< (fbx_pkg::COEF_FRAC - 1))) >>> fbx_pkg::COEF_FRAC;
    if (y_sh > SMAX) begin
      y_sat = SB'(SMAX);
    end else if (y_sh < SMIN) begin
      y_sat = SB'(SMIN);
    end else begin
      y_sat = SB'(y_sh);
    end
  end

  // state write back, also zero during the clearing pass
  always_comb begin
    mem_we    = (state == ST_WR) || (state == ST_CLEAR);
    mem_wdata = '0;
    if (state == ST_WR) begin
      mem_wdata = {fbx_pkg::state_round(acc1), fbx_pkg::state_round(acc2)};
    end
  end

  // mix of soloed bands, all bands when nothing is soloed
  always_comb begin
    mix_sum = '0;
    for (int k = 0; k < 4; k++) begin
      if (cfg.solo == 4'd0 || cfg.solo[k]) begin
        mix_sum = mix_sum + (SB+2)'(band[k]);
      end
    end
    if (mix_sum > MMAX) begin
      mix_sat = SB'(MMAX);
    end else if (mix_sum < MMIN) begin
      mix_sat = SB'(MMIN);
    end else begin
      mix_sat = SB'(mix_sum);
    end
  end

  assign ch_x14 = {ch_fold, 4'd0} - {3'd0, ch_fold, 1'b0};

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (row == AW'(ROWS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (sample_valid) state_next = ST_FOLD;
      ST_FOLD:  if ({1'b0, ch_fold} < CH_LIMIT) state_next = ST_RD;
      ST_RD:    state_next = ST_Y;
      ST_Y:     state_next = ST_P1;
      ST_P1:    state_next = ST_P2;
      ST_P2:    state_next = ST_P3;
      ST_P3:    state_next = ST_P4;
      ST_P4:    state_next = ST_WR;
      ST_WR: begin
        if (stage == 4'(fbx_pkg::STAGES - 1)) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_OUT:   if (!result_valid || result_ready) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  assign sample_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      row          <= '0;
      stage        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a new result may load in the same cycle the old one transfers out
      if (state == ST_OUT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          row <= (row == AW'(ROWS - 1)) ? '0 : row + 1'b1;
        end
        ST_FOLD: begin
          if ({1'b0, ch_fold} < CH_LIMIT) begin
            row   <= AW'(ch_x14);
            stage <= '0;
          end
        end
        ST_WR: begin
          row   <= row + 1'b1;
          stage <= stage + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          ch_id   <= channel;
          ch_fold <= channel;
          x_in    <= sample_in;
        end
      end
      ST_FOLD: begin
        // channel modulo CHANNELS by repeated subtraction
        if ({1'b0, ch_fold} >= CH_LIMIT) begin
          ch_fold <= ch_fold - CH_LIMIT[fbx_pkg::CHAN_BITS-1:0];
        end
      end
      ST_Y:  y_r  <= y_sat;
      ST_P1: acc1 <= prod;
      ST_P2: acc1 <= acc1 - prod + (64'(s2) <<< fbx_pkg::STATE_SHIFT);
      ST_P3: acc2 <= prod;
      ST_P4: acc2 <= acc2 - prod;
      ST_WR: begin
        prev <= y_r;
        case (si.dst)
          fbx_pkg::DST_LO:    lo      <= y_r;
          fbx_pkg::DST_HI:    hi      <= y_r;
          fbx_pkg::DST_BAND0: band[0] <= y_r;
          fbx_pkg::DST_BAND1: band[1] <= y_r;
          fbx_pkg::DST_BAND2: band[2] <= y_r;
          fbx_pkg::DST_BAND3: band[3] <= y_r;
          default: ;
        endcase
      end
      ST_OUT: begin
        if (!result_valid || result_ready) begin
          channel_out  <= ch_id;
          band_low     <= band[0];
          band_midlow  <= band[1];
          band_midhigh <= band[2];
          band_high    <= band[3];
          mix_out      <= mix_sat;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: design/fbx_check.sv
// ----------------------------------------------------------------------------
// fbx_check
// port-level checks of the crossover core, bound to the top level
// ----------------------------------------------------------------------------
module fbx_check #(
  parameter int SAMPLE_BITS = fbx_pkg::DEF_SAMPLE_BITS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic signed [SAMPLE_BITS-1:0] mix_out
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(mix_out))
    else $error("result changed while stalled");

  // one sample at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("second sample taken while busy");

  // a sample keeps sample_ready low through the fold and most of the biquad tree
  a_gap: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready [*98])
    else $error("sample taken before the tree finished");

  // reset empties the output
  a_rst: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_ready)
    else $error("output valid after reset");

endmodule

bind four_band_crossover_splitter_core fbx_check #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_fbx_check (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .mix_out      (mix_out)
);
